// File: design/s3f_pkg.sv
// Shared types, constants and helpers of the S3-FIFO cache replacement block.
// Used by the controller, the datapath and the top level.
package s3f_pkg;

    localparam int SMALL_DEPTH = 16;
    localparam int MAIN_DEPTH  = 128;
    localparam int GHOST_DEPTH = 128;
    localparam int KEY_BITS    = 32;

    localparam int S_AW = $clog2(SMALL_DEPTH);
    localparam int M_AW = $clog2(MAIN_DEPTH);
    localparam int G_AW = $clog2(GHOST_DEPTH);
    localparam int S_FW = S_AW + 1;
    localparam int M_FW = M_AW + 1;
    localparam int G_FW = G_AW + 1;
    localparam int MAX_FW = (S_FW > M_FW) ? ((S_FW > G_FW) ? S_FW : G_FW)
                                          : ((M_FW > G_FW) ? M_FW : G_FW);
    localparam int CNT_W = MAX_FW;

    localparam int USE_W  = 2;
    localparam int WORD_W = KEY_BITS + USE_W;
    localparam logic [USE_W-1:0] USE_MAX = 2'd3;

    localparam int SCAP_W = 5;
    localparam int MCAP_W = 8;
    localparam int GCAP_W = 8;
    localparam int CFG_W  = 8;
    localparam int CFG_AW = 2;
    localparam logic [SCAP_W-1:0] SCAP_RESET = 5'd16;
    localparam logic [MCAP_W-1:0] MCAP_RESET = 8'd128;
    localparam logic [GCAP_W-1:0] GCAP_RESET = 8'd128;

    localparam int IN_W  = 32;
    localparam int OUT_W = 8;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SMALL_CAP = 2'd0,
        CFG_MAIN_CAP  = 2'd1,
        CFG_GHOST_CAP = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        Q_NONE  = 2'd0,
        Q_SMALL = 2'd1,
        Q_MAIN  = 2'd2,
        Q_GHOST = 2'd3
    } queue_t;

    typedef struct packed {
        logic   load_key;
        logic   cnt_clr;
        logic   cnt_inc;
        queue_t rd_q;
        logic   rd_head;
        logic   use_vic;
        logic   bump_s;
        logic   bump_m;
        logic   s_pop;
        logic   s_push;
        logic   m_pop;
        logic   m_requeue;
        logic   m_push;
        logic   g_pop;
        logic   g_push;
        logic   out_load;
        logic   out_hit;
    } dp_cmd_t;

    typedef struct packed {
        logic s_end;
        logic m_end;
        logic g_end;
        logic s_match;
        logic m_match;
        logic g_match;
        logic s_full;
        logic m_full;
        logic g_full;
        logic s_empty;
        logic s_rc_gt1;
        logic m_rc_gt0;
        logic out_busy;
    } dp_stat_t;

    function automatic logic [USE_W-1:0] sat_inc(input logic [USE_W-1:0] c);
        return (c == USE_MAX) ? USE_MAX : c + 1'b1;
    endfunction

endpackage

// File: design/s3fifo_cache_replacement.sv
// Top level of the S3-FIFO cache replacement block: controller plus datapath.
// Depends on s3f_pkg, s3f_ctrl and s3f_dpath.
//
//   Channel   Direction  Word contents
//   s_        in         tdata[31:0] page_key
//   m_        out        tdata[0] hit, tdata[7:1] zero
//   cfg_      in         index 0 small, 1 main, 2 ghost capacity
//
// Each word is looked up by scanning small, main and ghost in turn (one RAM
// read and one compare per entry scanned); eviction pops main or small entries
// and drops ghost keys when the queue it inserts into is at capacity.
// Reset is synchronous; the queues come up empty and need no clearing pass.
// A result waits in the output register while m_tready is low; a new word
// is accepted once the block is back in idle.
module s3fifo_cache_replacement (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [s3f_pkg::IN_W-1:0]   s_tdata,   // [31:0] page_key
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [s3f_pkg::OUT_W-1:0]  m_tdata,   // [0] hit
    input  logic                       cfg_we,
    input  logic [s3f_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [s3f_pkg::CFG_W-1:0]  cfg_wdata
);
    import s3f_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    s3f_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .stat(stat), .cmd(cmd)
    );

    s3f_dpath u_dpath (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat), .s_tdata(s_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );
endmodule

// File: design/s3f_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module s3f_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: design/s3f_dpath.sv
// Datapath: the three queue memories, their pointers, capacity registers,
// key registers and the result register. Depends on s3f_pkg and s3f_ram.
module s3f_dpath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  s3f_pkg::dp_cmd_t        cmd,
    output s3f_pkg::dp_stat_t       stat,
    input  logic [s3f_pkg::IN_W-1:0]   s_tdata,
    input  logic                    cfg_we,
    input  logic [s3f_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [s3f_pkg::CFG_W-1:0]  cfg_wdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [s3f_pkg::OUT_W-1:0]  m_tdata
);
    import s3f_pkg::*;

    logic [KEY_BITS-1:0] key_reg, svic_reg, cmp_key;
    logic [CNT_W-1:0]    cnt_reg;
    logic [S_AW-1:0]     s_head_reg, s_last_reg, s_raddr, s_waddr;
    logic [S_FW-1:0]     s_fill_reg, scap;
    logic [M_AW-1:0]     m_head_reg, m_last_reg, m_raddr, m_waddr;
    logic [M_FW-1:0]     m_fill_reg, mcap;
    logic [G_AW-1:0]     g_head_reg, g_raddr, g_waddr;
    logic [G_FW-1:0]     g_fill_reg, gcap;
    logic [SCAP_W-1:0]   scap_reg;
    logic [MCAP_W-1:0]   mcap_reg;
    logic [GCAP_W-1:0]   gcap_reg;
    logic                out_valid_reg, out_hit_reg;
    logic [WORD_W-1:0]   s_rdata, m_rdata, s_wdata, m_wdata;
    logic [KEY_BITS-1:0] g_rdata;
    logic                s_we, m_we;

    assign scap = (scap_reg == '0) ? S_FW'(1) :
                  (32'(scap_reg) > SMALL_DEPTH) ? S_FW'(SMALL_DEPTH) : S_FW'(scap_reg);
    assign mcap = (mcap_reg == '0) ? M_FW'(1) :
                  (32'(mcap_reg) > MAIN_DEPTH) ? M_FW'(MAIN_DEPTH) : M_FW'(mcap_reg);
    assign gcap = (gcap_reg == '0) ? G_FW'(1) :
                  (32'(gcap_reg) > GHOST_DEPTH) ? G_FW'(GHOST_DEPTH) : G_FW'(gcap_reg);

    assign cmp_key = cmd.use_vic ? svic_reg : key_reg;

    assign s_raddr = cmd.rd_head ? s_head_reg : s_head_reg + cnt_reg[S_AW-1:0];
    assign m_raddr = cmd.rd_head ? m_head_reg : m_head_reg + cnt_reg[M_AW-1:0];
    assign g_raddr = g_head_reg + cnt_reg[G_AW-1:0];

    assign s_we    = cmd.bump_s | cmd.s_push;
    assign s_waddr = cmd.bump_s ? s_last_reg : s_head_reg + s_fill_reg[S_AW-1:0];
    assign s_wdata = cmd.bump_s ? {key_reg, sat_inc(s_rdata[USE_W-1:0])}
                                : {key_reg, {USE_W{1'b0}}};

    assign m_we    = cmd.bump_m | cmd.m_push | cmd.m_requeue;
    assign m_waddr = cmd.bump_m ? m_last_reg : m_head_reg + m_fill_reg[M_AW-1:0];
    always_comb begin
        if (cmd.bump_m) begin
            m_wdata = {key_reg, sat_inc(m_rdata[USE_W-1:0])};
        end else if (cmd.m_requeue) begin
            m_wdata = {m_rdata[WORD_W-1:USE_W], m_rdata[USE_W-1:0] - 1'b1};
        end else begin
            m_wdata = {cmp_key, {USE_W{1'b0}}};
        end
    end

    assign g_waddr = g_head_reg + g_fill_reg[G_AW-1:0];

    s3f_ram #(.WIDTH(WORD_W), .DEPTH(SMALL_DEPTH)) u_small (
        .aclk(aclk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .re(cmd.rd_q == Q_SMALL), .raddr(s_raddr), .rdata(s_rdata)
    );
    s3f_ram #(.WIDTH(WORD_W), .DEPTH(MAIN_DEPTH)) u_main (
        .aclk(aclk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .re(cmd.rd_q == Q_MAIN), .raddr(m_raddr), .rdata(m_rdata)
    );
    s3f_ram #(.WIDTH(KEY_BITS), .DEPTH(GHOST_DEPTH)) u_ghost (
        .aclk(aclk), .we(cmd.g_push), .waddr(g_waddr), .wdata(svic_reg),
        .re(cmd.rd_q == Q_GHOST), .raddr(g_raddr), .rdata(g_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_head_reg    <= '0;
            s_fill_reg    <= '0;
            m_head_reg    <= '0;
            m_fill_reg    <= '0;
            g_head_reg    <= '0;
            g_fill_reg    <= '0;
            scap_reg      <= SCAP_RESET;
            mcap_reg      <= MCAP_RESET;
            gcap_reg      <= GCAP_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_SMALL_CAP: scap_reg <= cfg_wdata[SCAP_W-1:0];
                    CFG_MAIN_CAP:  mcap_reg <= cfg_wdata[MCAP_W-1:0];
                    CFG_GHOST_CAP: gcap_reg <= cfg_wdata[GCAP_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.cnt_clr) begin
                cnt_reg <= '0;
            end else if (cmd.cnt_inc) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.s_pop) begin
                s_head_reg <= s_head_reg + 1'b1;
                s_fill_reg <= s_fill_reg - 1'b1;
            end else if (cmd.s_push) begin
                s_fill_reg <= s_fill_reg + 1'b1;
            end
            if (cmd.m_pop) begin
                m_head_reg <= m_head_reg + 1'b1;
                m_fill_reg <= m_fill_reg - 1'b1;
            end else if (cmd.m_requeue) begin
                m_head_reg <= m_head_reg + 1'b1;
            end else if (cmd.m_push) begin
                m_fill_reg <= m_fill_reg + 1'b1;
            end
            if (cmd.g_pop) begin
                g_head_reg <= g_head_reg + 1'b1;
                g_fill_reg <= g_fill_reg - 1'b1;
            end else if (cmd.g_push) begin
                g_fill_reg <= g_fill_reg + 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_key) begin
            key_reg <= s_tdata[KEY_BITS-1:0];
        end
        if (cmd.s_pop) begin
            svic_reg <= s_rdata[WORD_W-1:USE_W];
        end
        if (cmd.rd_q == Q_SMALL) begin
            s_last_reg <= s_raddr;
        end
        if (cmd.rd_q == Q_MAIN) begin
            m_last_reg <= m_raddr;
        end
        if (cmd.out_load) begin
            out_hit_reg <= cmd.out_hit;
        end
    end

    assign stat.s_end    = cnt_reg == CNT_W'(s_fill_reg);
    assign stat.m_end    = cnt_reg == CNT_W'(m_fill_reg);
    assign stat.g_end    = cnt_reg == CNT_W'(g_fill_reg);
    assign stat.s_match  = s_rdata[WORD_W-1:USE_W] == cmp_key;
    assign stat.m_match  = m_rdata[WORD_W-1:USE_W] == cmp_key;
    assign stat.g_match  = g_rdata == cmp_key;
    assign stat.s_full   = (s_fill_reg != '0) && (s_fill_reg >= scap);
    assign stat.m_full   = (m_fill_reg != '0) && (m_fill_reg >= mcap);
    assign stat.g_full   = (g_fill_reg != '0) && (g_fill_reg >= gcap);
    assign stat.s_empty  = s_fill_reg == '0;
    assign stat.s_rc_gt1 = s_rdata[USE_W-1:0] > 2'd1;
    assign stat.m_rc_gt0 = m_rdata[USE_W-1:0] != '0;
    assign stat.out_busy = out_valid_reg & ~m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-1){1'b0}}, out_hit_reg};
endmodule

// File: design/s3f_ctrl.sv
// Controller state machine: lookup scans, evictions and the insert sequence.
// Depends on s3f_pkg; drives the datapath through dp_cmd_t.
module s3f_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  s3f_pkg::dp_stat_t   stat,
    output s3f_pkg::dp_cmd_t    cmd
);
    import s3f_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_S_RD, ST_S_CMP, ST_M_RD, ST_M_CMP, ST_G_RD, ST_G_CMP,
        ST_MIN_CHK, ST_MEV_RD, ST_MEV_POP, ST_SIN_CHK, ST_SEV_RD, ST_SEV_POP,
        ST_SEV_CONT, ST_GEV_CHK, ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   vic_reg, vic_next, hit_reg, hit_next;

    always_comb begin
        state_next  = state_reg;
        vic_next    = vic_reg;
        hit_next    = hit_reg;
        cmd         = '0;
        cmd.use_vic = vic_reg;
        cmd.out_hit = hit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_key = 1'b1;
                    cmd.cnt_clr  = 1'b1;
                    vic_next     = 1'b0;
                    hit_next     = 1'b0;
                    state_next   = ST_S_RD;
                end
            end
            ST_S_RD: begin
                if (stat.s_end) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_M_RD;
                end else begin
                    cmd.rd_q   = Q_SMALL;
                    state_next = ST_S_CMP;
                end
            end
            ST_S_CMP: begin
                if (stat.s_match) begin
                    cmd.bump_s = 1'b1;
                    hit_next   = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_S_RD;
                end
            end
            ST_M_RD: begin
                if (stat.m_end) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_G_RD;
                end else begin
                    cmd.rd_q   = Q_MAIN;
                    state_next = ST_M_CMP;
                end
            end
            ST_M_CMP: begin
                if (stat.m_match) begin
                    cmd.bump_m = 1'b1;
                    hit_next   = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_M_RD;
                end
            end
            ST_G_RD: begin
                if (stat.g_end) begin
                    state_next = vic_reg ? ST_GEV_CHK : ST_SIN_CHK;
                end else begin
                    cmd.rd_q   = Q_GHOST;
                    state_next = ST_G_CMP;
                end
            end
            ST_G_CMP: begin
                if (stat.g_match) begin
                    state_next = vic_reg ? ST_SIN_CHK : ST_MIN_CHK;
                end else begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_G_RD;
                end
            end
            ST_MIN_CHK: begin
                if (stat.m_full) begin
                    state_next = ST_MEV_RD;
                end else begin
                    cmd.m_push = 1'b1;
                    state_next = vic_reg ? ST_SEV_CONT : ST_RESP;
                end
            end
            ST_MEV_RD: begin
                cmd.rd_q    = Q_MAIN;
                cmd.rd_head = 1'b1;
                state_next  = ST_MEV_POP;
            end
            ST_MEV_POP: begin
                if (stat.m_rc_gt0) begin
                    cmd.m_requeue = 1'b1;
                    state_next    = ST_MEV_RD;
                end else begin
                    cmd.m_pop  = 1'b1;
                    state_next = ST_MIN_CHK;
                end
            end
            ST_SIN_CHK: begin
                if (stat.s_full) begin
                    state_next = ST_SEV_RD;
                end else begin
                    cmd.s_push = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_SEV_RD: begin
                cmd.rd_q    = Q_SMALL;
                cmd.rd_head = 1'b1;
                state_next  = ST_SEV_POP;
            end
            ST_SEV_POP: begin
                cmd.s_pop = 1'b1;
                vic_next  = 1'b1;
                if (stat.s_rc_gt1) begin
                    state_next = ST_MIN_CHK;
                end else begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_G_RD;
                end
            end
            ST_SEV_CONT: begin
                state_next = stat.s_empty ? ST_SIN_CHK : ST_SEV_RD;
            end
            ST_GEV_CHK: begin
                if (stat.g_full) begin
                    cmd.g_pop = 1'b1;
                end else begin
                    cmd.g_push = 1'b1;
                    state_next = ST_SIN_CHK;
                end
            end
            ST_RESP: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            vic_reg   <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            vic_reg   <= vic_next;
            hit_reg   <= hit_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
endmodule

// File: design/s3f_checker.sv
// Port-level checks for the S3-FIFO cache replacement block, bound to its top.
// Depends on s3f_pkg.
module s3f_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [s3f_pkg::OUT_W-1:0]  m_tdata
);
    import s3f_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_W-1:1] == '0)
        else $error("result padding bits not zero");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while a lookup runs");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not idle after reset");
endmodule

bind s3fifo_cache_replacement s3f_checker u_s3f_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// File: test/s3fifo_cache_replacement_tb.sv
// Testbench for the S3-FIFO cache replacement block: drives page keys, predicts
// hit/miss with its own queue model and checks every result word. Uses s3f_pkg.
`timescale 1ns / 100ps

module s3fifo_cache_replacement_tb;
    import s3f_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    s3fifo_cache_replacement uut (.*);

    always #5 aclk = ~aclk;

    // Predictor state.
    logic [31:0] sk[SMALL_DEPTH];
    logic [1:0] sc[SMALL_DEPTH];
    int sh, sf;
    logic [31:0] mk[MAIN_DEPTH];
    logic [1:0] mc[MAIN_DEPTH];
    int mh, mf;
    logic [31:0] gk[GHOST_DEPTH];
    int gh, gf;
    int scap = 16, mcap = 128, gcap = 128;

    logic [31:0] pending_keys[$];
    logic expected_hits[$];
    int send_idle = 0, recv_idle = 0;
    int errors = 0, hits_seen = 0, words_seen = 0;
    longint cycles = 0;
    logic drv_on = 1'b0;
    logic in_taken = 1'b0;
    logic stall_req = 1'b0;
    int stall_cnt = 0;

    function automatic int eff_cap(int raw, int depth);
        if (raw == 0) return 1;
        if (raw > depth) return depth;
        return raw;
    endfunction

    task automatic main_push(logic [31:0] k, logic [1:0] c);
        if (mf >= MAIN_DEPTH) return;
        mk[(mh + mf) % MAIN_DEPTH] = k;
        mc[(mh + mf) % MAIN_DEPTH] = c;
        mf++;
    endtask

    task automatic main_evict();
        logic [31:0] k;
        logic [1:0] c;
        while (mf > 0) begin
            k = mk[mh];
            c = mc[mh];
            mh = (mh + 1) % MAIN_DEPTH;
            mf--;
            if (c > 0) main_push(k, c - 1);
            else break;
        end
    endtask

    task automatic main_insert(logic [31:0] k);
        while (mf > 0 && mf >= eff_cap(mcap, MAIN_DEPTH)) main_evict();
        main_push(k, 2'd0);
    endtask

    task automatic ghost_insert(logic [31:0] k);
        for (int i = 0; i < gf; i++)
            if (gk[(gh + i) % GHOST_DEPTH] == k) return;
        while (gf > 0 && gf >= eff_cap(gcap, GHOST_DEPTH)) begin
            gh = (gh + 1) % GHOST_DEPTH;
            gf--;
        end
        gk[(gh + gf) % GHOST_DEPTH] = k;
        gf++;
    endtask

    task automatic small_evict();
        logic [31:0] k;
        logic [1:0] c;
        while (sf > 0) begin
            k = sk[sh];
            c = sc[sh];
            sh = (sh + 1) % SMALL_DEPTH;
            sf--;
            if (c > 1) main_insert(k);
            else begin
                ghost_insert(k);
                break;
            end
        end
    endtask

    task automatic lookup_page(logic [31:0] k, output logic hit);
        int idx;
        logic in_ghost;
        in_ghost = 1'b0;
        hit = 1'b0;
        for (int i = 0; i < sf && !hit; i++) begin
            idx = (sh + i) % SMALL_DEPTH;
            if (sk[idx] == k) begin
                if (sc[idx] != 2'd3) sc[idx]++;
                hit = 1'b1;
            end
        end
        for (int i = 0; i < mf && !hit; i++) begin
            idx = (mh + i) % MAIN_DEPTH;
            if (mk[idx] == k) begin
                if (mc[idx] != 2'd3) mc[idx]++;
                hit = 1'b1;
            end
        end
        if (hit) return;
        for (int i = 0; i < gf; i++)
            if (gk[(gh + i) % GHOST_DEPTH] == k) in_ghost = 1'b1;
        if (in_ghost) main_insert(k);
        else begin
            while (sf > 0 && sf >= eff_cap(scap, SMALL_DEPTH)) small_evict();
            sk[(sh + sf) % SMALL_DEPTH] = k;
            sc[(sh + sf) % SMALL_DEPTH] = 2'd0;
            sf++;
        end
    endtask

    // Long receiver stall, counted in its own process.
    always @(negedge aclk) begin
        if (!stall_req) begin
            stall_cnt <= 0;
        end else if (stall_cnt < 400) begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // Driver: one word per handshake, fed from the pending queue; also drives m_tready.
    always @(negedge aclk) begin
        if (in_taken) begin
            pending_keys.delete(0);
        end
        if (!drv_on) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            s_tvalid <= 1'b1;
        end else if (pending_keys.size() > 0 && $urandom_range(99) >= send_idle) begin
            s_tvalid <= 1'b1;
            s_tdata <= pending_keys[0];
        end else begin
            s_tvalid <= 1'b0;
        end
        if (stall_req && stall_cnt < 400) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Predict at input acceptance, check at output acceptance.
    always @(posedge aclk) begin
        logic h;
        cycles <= cycles + 1;
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            lookup_page(s_tdata, h);
            expected_hits.push_back(h);
        end
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected word, actual hit=%0b", $time, m_tdata[0]);
                errors++;
            end else begin
                h = expected_hits[0];
                expected_hits.delete(0);
                hits_seen += h;
                if (m_tdata[0] !== h || m_tdata[7:1] !== 7'd0) begin
                    $display("%0t: hit mismatch, expected %0b actual %0h", $time, h, m_tdata);
                    errors++;
                end
            end
        end
        if (cycles > 20000000) begin
            $display("s3fifo_cache_replacement regression: fail");
            $finish;
        end
    end

    task automatic write_cfg(cfg_idx_t idx, int val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val[CFG_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SMALL_CAP: scap = val & 32'h1F;
            CFG_MAIN_CAP:  mcap = val & 32'hFF;
            default:       gcap = val & 32'hFF;
        endcase
    endtask

    task automatic run_phase(int n, int pool, int s_idle, int r_idle);
        logic [31:0] base;
        base = $urandom();
        send_idle = s_idle;
        recv_idle = r_idle;
        drv_on = 1'b1;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) pending_keys.push_back($urandom());
            else pending_keys.push_back(base ^ $urandom_range(pool - 1));
        end
        wait (pending_keys.size() == 0 && !s_tvalid);
        drv_on = 1'b0;
        wait (expected_hits.size() == 0);
        repeat (3000) @(posedge aclk);
    endtask

    initial begin
        sh = 0; sf = 0; mh = 0; mf = 0; gh = 0; gf = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // Directed: key extremes and repeated hits that saturate.
        drv_on = 1'b1;
        pending_keys = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
                         32'hFFFF_FFFF, 32'hAAAA_5555, 32'h5555_AAAA};
        wait (pending_keys.size() == 0 && !s_tvalid);
        wait (expected_hits.size() == 0);
        repeat (3000) @(posedge aclk);
        write_cfg(CFG_SMALL_CAP, 1);
        write_cfg(CFG_MAIN_CAP, 1);
        write_cfg(CFG_GHOST_CAP, 1);
        run_phase(60, 6, 0, 0);
        // Zero and oversize capacities, then long receiver hold-off.
        write_cfg(CFG_SMALL_CAP, 0);
        write_cfg(CFG_MAIN_CAP, 0);
        write_cfg(CFG_GHOST_CAP, 255);
        run_phase(60, 8, 13, 13);
        write_cfg(CFG_SMALL_CAP, 31);
        write_cfg(CFG_MAIN_CAP, 200);
        write_cfg(CFG_GHOST_CAP, 0);
        stall_req = 1'b1;
        run_phase(50, 40, 0, 0);
        stall_req = 1'b0;
        write_cfg(CFG_SMALL_CAP, 16);
        write_cfg(CFG_MAIN_CAP, 128);
        write_cfg(CFG_GHOST_CAP, 128);
        run_phase(400, 300, 0, 0);
        // Shrink below current fill.
        write_cfg(CFG_SMALL_CAP, 3);
        write_cfg(CFG_MAIN_CAP, 10);
        write_cfg(CFG_GHOST_CAP, 9);
        run_phase(300, 30, 50, 0);
        write_cfg(CFG_SMALL_CAP, $urandom_range(1, 16));
        write_cfg(CFG_MAIN_CAP, $urandom_range(1, 128));
        write_cfg(CFG_GHOST_CAP, $urandom_range(1, 128));
        run_phase(350, 80, 0, 50);
        run_phase(330, 60, 13, 13);
        $display("Covered %0d result words (%0d hits) over capacity extremes,",
                 words_seen, hits_seen);
        $display("shrinking queues, random idling and a long output stall.");
        if (errors == 0 && expected_hits.size() == 0) begin
            $display("s3fifo_cache_replacement regression: pass");
        end else begin
            $display("s3fifo_cache_replacement regression: fail");
        end
        $finish;
    end
endmodule
